@@ rtl/core/convex_hull_with_collinear_unit_macros.svh @@
// Assertion macros for the convex hull unit checker.
// Depends on nothing; included by the checker file only.
`ifndef CONVEX_HULL_WITH_COLLINEAR_UNIT_MACROS_SVH
`define CONVEX_HULL_WITH_COLLINEAR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHWC_ASSERT_NOW(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CHWC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// Property that follows a reset cycle.
`define CHWC_ASSERT_RESET(label, clk, rst, post, msg) \
  label: assert property (@(posedge clk) (rst) |=> (post)) else $error(msg);

`endif

@@ rtl/core/chwc_pkg.sv @@
// Shared types and constants of the convex hull unit.
// Used by every module of the block; depends on nothing.
package chwc_pkg;

  localparam int CW         = 10;
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int STK_DEPTH  = 2 * MAX_POINTS;
  localparam int STK_AW     = 7;
  localparam int DEP_W      = 8;
  localparam int DIF_W      = CW + 1;
  localparam int PRD_W      = 2 * DIF_W;
  localparam int SUM_W      = PRD_W + 1;
  localparam int CMD_DEPTH  = 4;
  localparam int CMD_AW     = 2;
  localparam int RES_DEPTH  = 2;
  localparam int RES_AW     = 1;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } pt_t;

  typedef struct packed {
    logic [CW-1:0] pt_x;
    logic [CW-1:0] pt_y;
    logic          final_point;
  } in_t;

  typedef struct packed {
    logic [CW-1:0] hull_x;
    logic [CW-1:0] hull_y;
    logic          hull_last;
  } out_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    pt_t  pt;
    logic store;
    logic run;
  } cmd_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_ANC_RD, B_ANC_CMP,
    B_SRT_RDI, B_SRT_LDI, B_SRT_RDJ, B_SRT_CRS, B_SRT_SQJ, B_SRT_CNT, B_SRT_WR,
    B_SCN_RDS, B_SCN_RDP, B_SCN_GOT, B_SCN_CHK, B_SCN_TST, B_SCN_SEC,
    B_COL_RDS, B_COL_RDP, B_COL_GOT, B_COL_MUL, B_COL_TST,
    B_EM_RD, B_EM_GET, B_EM_CHK, B_EM_CMP, B_EM_FIN
  } back_state_t;

endpackage

@@ rtl/core/chwc_front.sv @@
// Front end of the convex hull unit: accepts points and classifies them.
// Depends on chwc_pkg.
module chwc_front
  import chwc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  in_t  point,
  output logic full,
  input  logic cmd_full,
  output logic cmd_push,
  output cmd_t cmd
);

  logic [CNT_W-1:0] count;
  logic             accepted;

  assign full     = cmd_full;
  assign accepted = push & ~cmd_full;

  // A point is stored while the store has room; a final point always starts a run.
  always_comb begin
    cmd.pt.x  = point.pt_x;
    cmd.pt.y  = point.pt_y;
    cmd.store = (count < CNT_W'(MAX_POINTS));
    cmd.run   = point.final_point;
    cmd_push  = accepted & (cmd.store | cmd.run);
  end

  // Fill level as the back end will see it.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accepted) begin
      if (point.final_point) begin
        count <= '0;
      end else if (cmd.store) begin
        count <= count + CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/chwc_cmd_fifo.sv @@
// Short request queue between the front and the back.
// Depends on chwc_pkg.
module chwc_cmd_fifo
  import chwc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t              slots [CMD_DEPTH];
  logic [CMD_AW-1:0] wptr;
  logic [CMD_AW-1:0] rptr;
  logic [CMD_AW:0]   level;
  logic              do_wr;
  logic              do_rd;

  assign full    = (level == (CMD_AW+1)'(CMD_DEPTH));
  assign empty   = (level == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = slots[rptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (do_wr) wptr <= wptr + CMD_AW'(1);
      if (do_rd) rptr <= rptr + CMD_AW'(1);
      if (do_wr & ~do_rd) level <= level + (CMD_AW+1)'(1);
      else if (do_rd & ~do_wr) level <= level - (CMD_AW+1)'(1);
    end
  end

  // Payload slots.
  always_ff @(posedge clk) begin
    if (do_wr) slots[wptr] <= wr_data;
  end

endmodule

@@ rtl/core/chwc_res_fifo.sv @@
// Result queue that decouples the back from the receiver.
// Depends on chwc_pkg.
module chwc_res_fifo
  import chwc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  out_t wr_data,
  output logic full,
  input  logic rd_en,
  output out_t rd_data,
  output logic empty
);

  out_t              slots [RES_DEPTH];
  logic [RES_AW-1:0] wptr;
  logic [RES_AW-1:0] rptr;
  logic [RES_AW:0]   level;
  logic              do_wr;
  logic              do_rd;

  assign full    = (level == (RES_AW+1)'(RES_DEPTH));
  assign empty   = (level == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = slots[rptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (do_wr) wptr <= wptr + RES_AW'(1);
      if (do_rd) rptr <= rptr + RES_AW'(1);
      if (do_wr & ~do_rd) level <= level + (RES_AW+1)'(1);
      else if (do_rd & ~do_wr) level <= level - (RES_AW+1)'(1);
    end
  end

  // Payload slots.
  always_ff @(posedge clk) begin
    if (do_wr) slots[wptr] <= wr_data;
  end

endmodule

@@ rtl/core/chwc_back.sv @@
// Back end of the convex hull unit: point store, anchor search, rank sort,
// Graham scan with collinear points kept, and de-duplicated emission.
// Depends on chwc_pkg.
module chwc_back
  import chwc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output out_t res_data
);

  function automatic logic signed [DIF_W-1:0] cdiff(input logic [CW-1:0] a,
                                                     input logic [CW-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  back_state_t state;
  back_state_t state_next;

  // Memories.
  pt_t              pstore  [MAX_POINTS];
  logic [IDX_W-1:0] sorted  [MAX_POINTS];
  pt_t              stack   [STK_DEPTH];
  pt_t              emitted [MAX_POINTS];

  pt_t              ps_rd;
  logic [IDX_W-1:0] so_rd;
  pt_t              st_rd;
  pt_t              em_rd;

  logic             ps_we;
  logic [IDX_W-1:0] ps_waddr;
  logic [IDX_W-1:0] ps_raddr;
  logic             so_we;
  logic [IDX_W-1:0] so_raddr;
  logic             st_we;
  logic [STK_AW-1:0] st_waddr;
  pt_t              st_wdata;
  logic [STK_AW-1:0] st_raddr;
  logic             em_we;
  logic [IDX_W-1:0] em_raddr;

  // Run control and datapath registers.
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] rank;
  pt_t              anchor;
  logic signed [DIF_W-1:0] aix, aiy, ajx, ajy;
  logic signed [PRD_W-1:0] sqi_x, sqi_y, sqj_x, sqj_y, crs_a, crs_b;
  pt_t              top, sec, rpt;
  logic [DEP_W-1:0] depth;
  logic signed [PRD_W-1:0] t1, t2;
  logic [DEP_W-1:0] e;
  logic [CNT_W-1:0] ecnt;
  logic [CNT_W-1:0] k;
  pt_t              cand;
  pt_t              pend;
  logic             have_pend;

  // Combinational helpers.
  logic signed [DIF_W-1:0] dx_new, dy_new;
  logic signed [SUM_W-1:0] di, dj;
  logic              zi, zj, bji, bij, inc;
  pt_t               tp;
  logic signed [DIF_W-1:0] dqy, drx, dqx, dry;
  logic              push_do;
  logic              stk_room;
  logic              em_new;
  logic              res_ready;
  logic              last_j;
  logic              last_i;

  assign res_ready = ~res_full;
  assign last_j    = (j + CNT_W'(1) == n);
  assign last_i    = (i + CNT_W'(1) == n);
  assign stk_room  = (depth < DEP_W'(STK_DEPTH));

  // Offsets from the anchor of the point just read.
  assign dx_new = cdiff(ps_rd.x, anchor.x);
  assign dy_new = cdiff(ps_rd.y, anchor.y);

  // Angular compare of point j against point i around the anchor.
  always_comb begin
    di  = SUM_W'(sqi_x) + SUM_W'(sqi_y);
    dj  = SUM_W'(sqj_x) + SUM_W'(sqj_y);
    zi  = (aix == '0) && (aiy == '0);
    zj  = (ajx == '0) && (ajy == '0);
    if (zi && zj) begin
      bji = 1'b0;
      bij = 1'b0;
    end else if (zj) begin
      bji = 1'b1;
      bij = 1'b0;
    end else if (zi) begin
      bji = 1'b0;
      bij = 1'b1;
    end else if (crs_a > crs_b) begin
      bji = 1'b1;
      bij = 1'b0;
    end else if (crs_a < crs_b) begin
      bji = 1'b0;
      bij = 1'b1;
    end else begin
      bji = (dj < di);
      bij = (di < dj);
    end
    inc = bji | ((j < i) & ~bij & ~bji);
  end

  // Turn operands: the base point is the anchor in the collinear pass.
  always_comb begin
    tp  = (state == B_COL_MUL) ? anchor : sec;
    dqy = cdiff(top.y, tp.y);
    drx = cdiff(rpt.x, top.x);
    dqx = cdiff(top.x, tp.x);
    dry = cdiff(rpt.y, top.y);
  end

  // Pushes onto the hull stack.
  always_comb begin
    push_do = ((state == B_SCN_CHK) && (depth <= DEP_W'(1))) ||
              ((state == B_SCN_TST) && !(t1 > t2)) ||
              ((state == B_COL_TST) && (t1 == t2));
    em_new  = (state == B_EM_CHK) && (k == ecnt);
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:    if (cmd_valid && cmd.run) state_next = B_ANC_RD;
      B_ANC_RD:  state_next = B_ANC_CMP;
      B_ANC_CMP: state_next = last_j ? B_SRT_RDI : B_ANC_RD;
      B_SRT_RDI: state_next = B_SRT_LDI;
      B_SRT_LDI: state_next = B_SRT_RDJ;
      B_SRT_RDJ: state_next = B_SRT_CRS;
      B_SRT_CRS: state_next = B_SRT_SQJ;
      B_SRT_SQJ: state_next = B_SRT_CNT;
      B_SRT_CNT: state_next = last_j ? B_SRT_WR : B_SRT_RDJ;
      B_SRT_WR:  state_next = last_i ? B_SCN_RDS : B_SRT_RDI;
      B_SCN_RDS: state_next = (i == n) ? B_COL_RDS : B_SCN_RDP;
      B_SCN_RDP: state_next = B_SCN_GOT;
      B_SCN_GOT: state_next = B_SCN_CHK;
      B_SCN_CHK: state_next = (depth > DEP_W'(1)) ? B_SCN_TST : B_SCN_RDS;
      B_SCN_TST: begin
        if (t1 > t2) begin
          state_next = (depth - DEP_W'(1) > DEP_W'(1)) ? B_SCN_SEC : B_SCN_CHK;
        end else begin
          state_next = B_SCN_RDS;
        end
      end
      B_SCN_SEC: state_next = B_SCN_CHK;
      B_COL_RDS: state_next = B_COL_RDP;
      B_COL_RDP: state_next = B_COL_GOT;
      B_COL_GOT: state_next = B_COL_MUL;
      B_COL_MUL: state_next = B_COL_TST;
      B_COL_TST: state_next = (i == CNT_W'(1)) ? B_EM_RD : B_COL_RDS;
      B_EM_RD:   state_next = (e == depth) ? B_EM_FIN : B_EM_GET;
      B_EM_GET:  state_next = B_EM_CHK;
      B_EM_CHK: begin
        if (!em_new) state_next = B_EM_CMP;
        else if (!have_pend || res_ready) state_next = B_EM_RD;
      end
      B_EM_CMP:  state_next = (em_rd == cand) ? B_EM_RD : B_EM_CHK;
      B_EM_FIN:  if (res_ready) state_next = B_IDLE;
      default:   state_next = B_IDLE;
    endcase
  end

  // Memory ports and handshake outputs.
  always_comb begin
    cmd_pop  = 1'b0;
    ps_we    = 1'b0;
    ps_waddr = n[IDX_W-1:0];
    ps_raddr = '0;
    so_we    = 1'b0;
    so_raddr = '0;
    st_we    = 1'b0;
    st_waddr = depth[STK_AW-1:0];
    st_wdata = rpt;
    st_raddr = '0;
    em_we    = 1'b0;
    em_raddr = k[IDX_W-1:0];
    res_push = 1'b0;
    res_data.hull_x    = pend.x;
    res_data.hull_y    = pend.y;
    res_data.hull_last = 1'b0;
    case (state)
      B_IDLE: begin
        cmd_pop = cmd_valid;
        ps_we   = cmd_valid & cmd.store;
      end
      B_ANC_RD:  ps_raddr = j[IDX_W-1:0];
      B_SRT_RDI: ps_raddr = i[IDX_W-1:0];
      B_SRT_RDJ: ps_raddr = j[IDX_W-1:0];
      B_SRT_WR: begin
        so_we = 1'b1;
        if (last_i) begin
          st_we    = 1'b1;
          st_waddr = '0;
          st_wdata = anchor;
        end
      end
      B_SCN_RDS: so_raddr = i[IDX_W-1:0];
      B_SCN_RDP: ps_raddr = so_rd;
      B_SCN_CHK: st_we = push_do & stk_room;
      B_SCN_TST: begin
        st_we    = push_do & stk_room;
        st_raddr = STK_AW'(depth - DEP_W'(3));
      end
      B_COL_RDS: so_raddr = IDX_W'(i - CNT_W'(1));
      B_COL_RDP: ps_raddr = so_rd;
      B_COL_TST: st_we = push_do & stk_room;
      B_EM_RD:   st_raddr = e[STK_AW-1:0];
      B_EM_CHK: begin
        em_we    = em_new & (~have_pend | res_ready);
        res_push = em_new & have_pend & res_ready;
      end
      B_EM_FIN: begin
        res_push           = res_ready;
        res_data.hull_last = 1'b1;
      end
      default: ;
    endcase
  end

  // Point store.
  always_ff @(posedge clk) begin
    if (ps_we) pstore[ps_waddr] <= cmd.pt;
    ps_rd <= pstore[ps_raddr];
  end

  // Sorted index list.
  always_ff @(posedge clk) begin
    if (so_we) sorted[rank[IDX_W-1:0]] <= i[IDX_W-1:0];
    so_rd <= sorted[so_raddr];
  end

  // Hull stack.
  always_ff @(posedge clk) begin
    if (st_we) stack[st_waddr] <= st_wdata;
    st_rd <= stack[st_raddr];
  end

  // Points already emitted, for de-duplication.
  always_ff @(posedge clk) begin
    if (em_we) emitted[ecnt[IDX_W-1:0]] <= cand;
    em_rd <= emitted[em_raddr];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // Control counters that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= '0;
      depth     <= '0;
      have_pend <= 1'b0;
      anchor    <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (cmd_valid && cmd.store) n <= n + CNT_W'(1);
        end
        B_ANC_CMP: begin
          if ((j == '0) || (ps_rd.y < anchor.y) ||
              ((ps_rd.y == anchor.y) && (ps_rd.x < anchor.x))) begin
            anchor <= ps_rd;
          end
        end
        B_SRT_WR: begin
          if (last_i) depth <= DEP_W'(1);
        end
        B_SCN_TST: begin
          if (t1 > t2) depth <= depth - DEP_W'(1);
          else if (stk_room) depth <= depth + DEP_W'(1);
        end
        B_SCN_CHK, B_COL_TST: begin
          if (push_do && stk_room) depth <= depth + DEP_W'(1);
        end
        B_COL_GOT: have_pend <= 1'b0;
        B_EM_CHK: begin
          if (em_new && (!have_pend || res_ready)) have_pend <= 1'b1;
        end
        B_EM_FIN: begin
          if (res_ready) begin
            n         <= '0;
            have_pend <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: j <= '0;
      B_ANC_CMP: begin
        j <= j + CNT_W'(1);
        i <= '0;
      end
      B_SRT_LDI: begin
        aix   <= dx_new;
        aiy   <= dy_new;
        sqi_x <= dx_new * dx_new;
        sqi_y <= dy_new * dy_new;
        j     <= '0;
        rank  <= '0;
      end
      B_SRT_CRS: begin
        ajx   <= dx_new;
        ajy   <= dy_new;
        crs_a <= dx_new * aiy;
        crs_b <= dy_new * aix;
      end
      B_SRT_SQJ: begin
        sqj_x <= ajx * ajx;
        sqj_y <= ajy * ajy;
      end
      B_SRT_CNT: begin
        rank <= rank + CNT_W'(inc);
        j    <= j + CNT_W'(1);
      end
      B_SRT_WR: begin
        i <= last_i ? CNT_W'(1) : i + CNT_W'(1);
        if (last_i) top <= anchor;
      end
      B_SCN_GOT, B_COL_GOT: rpt <= ps_rd;
      B_SCN_CHK: begin
        if (depth > DEP_W'(1)) begin
          t1 <= dqy * drx;
          t2 <= dqx * dry;
        end else begin
          i <= i + CNT_W'(1);
          if (stk_room) begin
            sec <= top;
            top <= rpt;
          end
        end
      end
      B_SCN_TST: begin
        if (t1 > t2) begin
          top <= sec;
        end else begin
          i <= i + CNT_W'(1);
          if (stk_room) begin
            sec <= top;
            top <= rpt;
          end
        end
      end
      B_SCN_SEC: sec <= st_rd;
      B_COL_MUL: begin
        t1 <= dqy * drx;
        t2 <= dqx * dry;
      end
      B_COL_TST: begin
        i <= i - CNT_W'(1);
        if (push_do && stk_room) begin
          sec <= top;
          top <= rpt;
        end
        e    <= '0;
        ecnt <= '0;
      end
      B_EM_GET: begin
        cand <= st_rd;
        k    <= '0;
      end
      B_EM_CHK: begin
        if (em_new && (!have_pend || res_ready)) begin
          ecnt <= ecnt + CNT_W'(1);
          pend <= cand;
          e    <= e + DEP_W'(1);
        end
      end
      B_EM_CMP: begin
        if (em_rd == cand) e <= e + DEP_W'(1);
        else k <= k + CNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/convex_hull_with_collinear_unit.sv @@
// Convex hull unit that keeps collinear boundary points.
// Input queue: push/full carries one point (x, y, final mark) per request.
// Output queue: empty/pop carries one hull point per request, in scan order,
// with hull_last on the final point of each run.
// Points load at one per cycle while there is room in the four-deep request
// queue; a point arriving when 64 are stored is dropped, but a final mark still
// starts the run. A run goes through the anchor search, the rank sort (one
// compare per stored point per pass through the single read port of the point
// store), the scan, the collinear pass, and the removal of duplicates, which
// compares each stack entry against the points already sent.
// Synchronous reset empties both queues and clears the point count.
// A stalled receiver fills the two-deep result queue, which halts the back
// end; the front keeps taking points until the request queue is full.
// Depends on chwc_pkg and the chwc_* submodules.
module convex_hull_with_collinear_unit
  import chwc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  point,
  output logic empty,
  input  logic pop,
  output out_t hull
);

  logic cmd_full;
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_pop;
  cmd_t cmd_out;
  logic cmd_empty;
  logic res_full;
  logic res_push;
  out_t res_data;

  // Classify incoming points.
  chwc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .point    (point),
    .full     (full),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // Request queue between front and back.
  chwc_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  // Hull computation.
  chwc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (~cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // Result queue toward the receiver.
  chwc_res_fifo u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (hull),
    .empty   (empty)
  );

endmodule

@@ rtl/core/chwc_checker.sv @@
// Port-level checker for the convex hull unit, bound to the top level.
// Depends on chwc_pkg and convex_hull_with_collinear_unit_macros.svh.
`include "convex_hull_with_collinear_unit_macros.svh"

module chwc_checker
  import chwc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input in_t  point,
  input logic empty,
  input logic pop,
  input out_t hull
);

  logic [3:0] runs;

  // Runs started by a final point whose last result has not been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      runs <= '0;
    end else begin
      case ({push & ~full & point.final_point, pop & ~empty & hull.hull_last})
        2'b10:   runs <= runs + 4'd1;
        2'b01:   runs <= runs - 4'd1;
        default: runs <= runs;
      endcase
    end
  end

  `CHWC_ASSERT_RESET(a_reset_empty, clk, rst, empty, "result queue not empty after reset")
  `CHWC_ASSERT_RESET(a_reset_full, clk, rst, !full, "input side full after reset")
  `CHWC_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(hull), "stalled result changed")
  `CHWC_ASSERT_NOW(a_no_orphan, clk, rst, !empty, runs != 4'd0, "result without a started run")

endmodule

bind convex_hull_with_collinear_unit chwc_checker u_chwc_checker (.*);

@@ dv/convex_hull_with_collinear_unit_tb.sv @@
// Testbench for the convex hull unit: sends point sets through the request
// queue and checks every hull point against a built-in hull predictor.
// Depends on chwc_pkg and the convex_hull_with_collinear_unit RTL.
`timescale 1ns / 1ps

module convex_hull_with_collinear_unit_tb;
  import chwc_pkg::*;

  localparam int STALL_LIMIT = 200000;
  localparam int LONG_HOLD   = 400;

  logic clk;
  logic rst;
  logic push;
  logic full;
  in_t  point;
  logic empty;
  logic pop;
  out_t hull;

  // Predictor state: the current point set and the hull points still due.
  logic [CW-1:0] set_x [MAX_POINTS];
  logic [CW-1:0] set_y [MAX_POINTS];
  int            set_count;
  out_t          hull_due [$];

  int  n_errors;
  int  n_sent;
  bit  idle_on;
  int  hold_off;
  int  stall_asks;
  int  stall_seen;
  int  quiet_cycles;
  bit  in_accepted;

  convex_hull_with_collinear_unit u_top (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .point (point),
    .empty (empty),
    .pop   (pop),
    .hull  (hull)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Orientation of p, q, r: positive is a clockwise turn, zero is collinear.
  function automatic longint turn_sign(int pi, int qi, int ri);
    longint dy1, dx2, dx1, dy2;
    dy1 = longint'(set_y[qi]) - longint'(set_y[pi]);
    dx2 = longint'(set_x[ri]) - longint'(set_x[qi]);
    dx1 = longint'(set_x[qi]) - longint'(set_x[pi]);
    dy2 = longint'(set_y[ri]) - longint'(set_y[qi]);
    return dy1 * dx2 - dx1 * dy2;
  endfunction

  // True when point a sorts strictly ahead of point b around the anchor.
  function automatic bit sorts_ahead(int a, int b, int anc);
    longint ax, ay, bx, by, cr;
    bit za, zb;
    ax = longint'(set_x[a]) - longint'(set_x[anc]);
    ay = longint'(set_y[a]) - longint'(set_y[anc]);
    bx = longint'(set_x[b]) - longint'(set_x[anc]);
    by = longint'(set_y[b]) - longint'(set_y[anc]);
    za = (ax == 0 && ay == 0);
    zb = (bx == 0 && by == 0);
    if (za && zb) return 1'b0;
    if (za) return 1'b1;
    if (zb) return 1'b0;
    cr = ax * by - ay * bx;
    if (cr != 0) return cr > 0;
    return ax * ax + ay * ay < bx * bx + by * by;
  endfunction

  // Computes the hull of the stored set and queues its distinct points.
  function automatic void predict_hull();
    int anc, key, j, dep, emitted;
    int order [MAX_POINTS];
    int stk [STK_DEPTH];
    out_t item;
    out_t run_pts [$];
    bit seen;
    anc = 0;
    for (int i = 1; i < set_count; i++)
      if (set_y[i] < set_y[anc] || (set_y[i] == set_y[anc] && set_x[i] < set_x[anc]))
        anc = i;
    for (int i = 0; i < set_count; i++) order[i] = i;
    for (int i = 1; i < set_count; i++) begin
      key = order[i];
      j = i;
      while (j > 0 && sorts_ahead(key, order[j-1], anc)) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    // Graham scan that pops only on a clockwise turn.
    dep = 0;
    stk[dep++] = anc;
    for (int i = 1; i < set_count; i++) begin
      while (dep > 1 && turn_sign(stk[dep-2], stk[dep-1], order[i]) > 0) dep--;
      if (dep < STK_DEPTH) stk[dep++] = order[i];
    end
    // Points collinear with the anchor and the top, walked in reverse order.
    for (int i = set_count; i > 0; i--)
      if (turn_sign(anc, stk[dep-1], order[i-1]) == 0 && dep < STK_DEPTH)
        stk[dep++] = order[i-1];
    // Keep the first occurrence of each coordinate pair.
    emitted = 0;
    for (int i = 0; i < dep && emitted < MAX_POINTS; i++) begin
      seen = 1'b0;
      foreach (run_pts[k])
        if (run_pts[k].hull_x == set_x[stk[i]] && run_pts[k].hull_y == set_y[stk[i]])
          seen = 1'b1;
      if (!seen) begin
        item.hull_x = set_x[stk[i]];
        item.hull_y = set_y[stk[i]];
        item.hull_last = 1'b0;
        run_pts = {run_pts, item};
        emitted++;
      end
    end
    if (emitted > 0) run_pts[emitted-1].hull_last = 1'b1;
    hull_due = {hull_due, run_pts};
    set_count = 0;
  endfunction

  // Updates the predictor with one accepted point.
  function automatic void take_point(in_t p);
    if (set_count < MAX_POINTS) begin
      set_x[set_count] = p.pt_x;
      set_y[set_count] = p.pt_y;
      set_count++;
    end
    if (p.final_point && set_count > 0) predict_hull();
  endfunction

  // Sends one point request, with an optional random gap ahead of it.
  task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                            input logic fin);
    in_t p;
    int gap;
    p.pt_x = x;
    p.pt_y = y;
    p.final_point = fin;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push  <= 1'b1;
    point <= p;
    do @(posedge clk); while (full);
    take_point(p);
    n_sent++;
  endtask

  function automatic logic [CW-1:0] rand_coord(int span);
    if (span >= 1023) begin
      case ($urandom_range(0, 9))
        0: return '0;
        1: return '1;
        default: return CW'($urandom_range(0, 1023));
      endcase
    end
    return CW'($urandom_range(0, span));
  endfunction

  // Sends one random set of the given size, final mark on its last point.
  task automatic send_random_set(int size);
    int span;
    int base_x, base_y;
    span = ($urandom_range(0, 2) == 0) ? 1023 : $urandom_range(1, 15);
    base_x = (span < 1023) ? $urandom_range(0, 1023 - span) : 0;
    base_y = (span < 1023) ? $urandom_range(0, 1023 - span) : 0;
    for (int i = 0; i < size; i++)
      send_point(CW'(base_x) + rand_coord(span), CW'(base_y) + rand_coord(span),
                 i == size - 1);
  endtask

  // Result side: checks each accepted hull point and drives pop.
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      pop        <= 1'b0;
      hold_off   <= 0;
      stall_seen <= 0;
    end else begin
      if (pop && !empty) begin
        if (hull_due.size() == 0) begin
          $display("%0t: unexpected hull point, expected none, actual %h", $time, hull);
          n_errors++;
        end else begin
          want = hull_due.pop_front();
          if (hull.hull_x !== want.hull_x || hull.hull_y !== want.hull_y ||
              hull.hull_last !== want.hull_last) begin
            $display("%0t: hull mismatch, expected x=%0d y=%0d last=%0d, actual x=%0d y=%0d last=%0d",
                     $time, want.hull_x, want.hull_y, want.hull_last,
                     hull.hull_x, hull.hull_y, hull.hull_last);
            n_errors++;
          end
        end
      end
      // A long hold-off asked for by a test starts here and is counted down below.
      if (stall_seen != stall_asks) begin
        stall_seen <= stall_asks;
        hold_off   <= LONG_HOLD;
        pop        <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold_off <= $urandom_range(1, 10);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles in which neither side accepts a request.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("convex_hull_with_collinear_unit_tb: errors");
        $finish;
      end
    end
  end

  task automatic test_directed();
    // Single point, then identical points.
    send_point(10'd5, 10'd7, 1'b1);
    send_point(10'd3, 10'd3, 1'b0);
    send_point(10'd3, 10'd3, 1'b0);
    send_point(10'd3, 10'd3, 1'b1);
    // Corner extremes with a midpoint on an edge and one inside.
    send_point(10'd1023, 10'd1023, 1'b0);
    send_point(10'd0, 10'd0, 1'b0);
    send_point(10'd1023, 10'd0, 1'b0);
    send_point(10'd512, 10'd0, 1'b0);
    send_point(10'd0, 10'd1023, 1'b0);
    send_point(10'd500, 10'd500, 1'b1);
    // All points on one line.
    send_point(10'd4, 10'd4, 1'b0);
    send_point(10'd1, 10'd1, 1'b0);
    send_point(10'd8, 10'd8, 1'b0);
    send_point(10'd2, 10'd2, 1'b1);
    // Anchor tie in y, and collinear points on the closing edge.
    send_point(10'd6, 10'd0, 1'b0);
    send_point(10'd2, 10'd0, 1'b0);
    send_point(10'd2, 10'd4, 1'b0);
    send_point(10'd2, 10'd2, 1'b0);
    send_point(10'd6, 10'd4, 1'b1);
  endtask

  // Fills the store, then sends points that are dropped; the last starts the run.
  task automatic test_store_full();
    for (int i = 0; i < MAX_POINTS; i++)
      send_point(rand_coord(1023), rand_coord(1023), 1'b0);
    send_point(10'h2AA, 10'h155, 1'b0);
    send_point(10'h155, 10'h2AA, 1'b1);
  endtask

  task automatic test_random(int target);
    while (n_sent < target)
      send_random_set(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12));
  endtask

  // Receiver stalls for a long stretch while several sets are offered.
  task automatic test_backpressure();
    stall_asks++;
    for (int i = 0; i < 4; i++) send_random_set($urandom_range(3, 8));
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    point = '0;
    set_count = 0;
    n_errors = 0;
    n_sent = 0;
    idle_on = 1'b1;
    stall_asks = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_backpressure();
    test_random(350);
    idle_on = 1'b0;
    test_random(410);
    push <= 1'b0;
    while (hull_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0) begin
      $display("convex_hull_with_collinear_unit_tb: clean");
    end else begin
      $display("convex_hull_with_collinear_unit_tb: errors");
    end
    $finish;
  end

endmodule
